[design/url_pkg.sv]
// url_pkg: shared types and constants of the upload rate meter.
// Used by upload_rate_meter; depends on nothing.
package url_pkg;

	localparam int unsigned WordW     = 32;
	localparam int unsigned CfgIdxW   = 8;
	localparam int unsigned ByteShift = 3;              // bits per byte = 2**3
	localparam int unsigned DividendW = WordW + ByteShift;
	localparam int unsigned DivSteps  = DividendW;
	localparam int unsigned CntW      = $clog2(DivSteps + 1);

	localparam logic [CfgIdxW-1:0] IDX_SAMPLE_INTERVAL = 8'd0;
	localparam logic [CfgIdxW-1:0] IDX_MIN_BYTES       = 8'd1;
	localparam logic [CfgIdxW-1:0] IDX_MAX_RATE        = 8'd2;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_RESET  = 1'b1;

	localparam logic [WordW-1:0] SAMPLE_INTERVAL_RST = 32'd1000;
	localparam logic [WordW-1:0] MIN_BYTES_RST       = 32'd0;
	localparam logic [WordW-1:0] MAX_RATE_RST        = 32'd100000;

	typedef struct packed {
		logic             command;
		logic [WordW-1:0] time_ms;
		logic [WordW-1:0] total_bytes;
	} sample_item_t;

	typedef struct packed {
		logic [WordW-1:0] rate_kbps;
	} rate_item_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [WordW-1:0]   value;
	} cfg_item_t;

endpackage

[design/url_stream_if.sv]
// url_stream_if: valid/ready channel carrying one beat of payload type T.
// Depends on nothing; the payload type is given at instantiation.
interface url_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/upload_rate_meter.sv]
// upload_rate_meter: upload rate in kbit/s from a running byte total and a ms clock.
// Depends on url_pkg and url_stream_if.
//
// Short path: a beat that yields 0 without a measurement registers that 0 directly.
// Measured rate: 35 steps of the restoring divider, then 1 clamp step.
// Throughput: one beat per cycle for the short path while the output is taken; a new
// beat waits out divide and clamp on the single one-bit-per-cycle subtract/compare unit.
// Reset: baseline cleared, meter not armed, config registers at their reset values.
module upload_rate_meter
	import url_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	url_stream_if.sink           cfg,
	url_stream_if.sink           sample,
	url_stream_if.source         rate
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]           state_q;
	logic [WordW-1:0]     interval_q, min_bytes_q, max_rate_q;
	logic [WordW-1:0]     base_time_q, base_bytes_q;
	logic                 armed_q;
	logic [WordW-1:0]     divisor_q;
	logic [WordW-1:0]     rem_q;
	logic [DividendW-1:0] quo_q;
	logic [CntW-1:0]      cnt_q;
	logic                 out_valid_q;
	logic [WordW-1:0]     out_rate_q;

	sample_item_t         item;
	logic                 out_free;
	logic                 accept;
	logic [WordW-1:0]     elapsed, sent;
	logic                 rebase_only, too_soon;
	logic                 go_div;
	logic                 out_set;
	logic [WordW:0]       shifted;
	logic                 ge;
	logic [WordW:0]       trial;
	logic [DividendW-1:0] quo_min1;
	logic [WordW-1:0]     clamped;

	assign item     = sample.data;
	assign out_free = !out_valid_q || rate.ready;
	assign sample.ready = (state_q == ST_IDLE) && out_free;
	assign accept   = sample.valid && sample.ready;
	assign cfg.ready = 1'b1;

	assign elapsed     = item.time_ms - base_time_q;
	assign sent        = item.total_bytes - base_bytes_q;
	assign rebase_only = (item.command == CMD_RESET) || !armed_q;
	assign too_soon    = elapsed < interval_q;
	assign go_div      = !rebase_only && !too_soon && !(sent < min_bytes_q);
	assign out_set     = (state_q == ST_IDLE && accept && !go_div) ||
	                     (state_q == ST_FIN && out_free);

	// one restoring step
	assign shifted = {rem_q, quo_q[DividendW-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign trial   = shifted - {1'b0, divisor_q};

	always_comb begin
		quo_min1 = (quo_q == '0) ? DividendW'(1) : quo_q;
		if (quo_min1 > {{ByteShift{1'b0}}, max_rate_q}) begin
			clamped = max_rate_q;
		end else begin
			clamped = quo_min1[WordW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= SAMPLE_INTERVAL_RST;
			min_bytes_q <= MIN_BYTES_RST;
			max_rate_q  <= MAX_RATE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				IDX_SAMPLE_INTERVAL: interval_q  <= cfg.data.value;
				IDX_MIN_BYTES:       min_bytes_q <= cfg.data.value;
				IDX_MAX_RATE:        max_rate_q  <= cfg.data.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_set) begin
			out_valid_q <= 1'b1;
		end else if (rate.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			armed_q      <= 1'b0;
			base_time_q  <= '0;
			base_bytes_q <= '0;
			cnt_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (rebase_only || !too_soon) begin
							base_time_q  <= item.time_ms;
							base_bytes_q <= item.total_bytes;
							armed_q      <= 1'b1;
						end
						if (go_div) begin
							state_q <= ST_DIV;
							cnt_q   <= '0;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(DivSteps - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_rate_q <= '0;
			divisor_q  <= elapsed;
			rem_q      <= '0;
			quo_q      <= {sent, {ByteShift{1'b0}}};
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? trial[WordW-1:0] : shifted[WordW-1:0];
			quo_q <= {quo_q[DividendW-2:0], ge};
		end else if (state_q == ST_FIN && out_free) begin
			out_rate_q <= clamped;
		end
	end

	assign rate.valid          = out_valid_q;
	assign rate.data.rate_kbps = out_rate_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> state_q == ST_IDLE)
		else $error("input ready outside idle");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CntW'(DivSteps))
		else $error("divider step count out of range");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (state_q == ST_IDLE && rate.valid))
		else $error("finished rate not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!rate.valid || rate.ready))
		else $error("beat accepted over a pending result");

endmodule
